>>> hw/rtl/adaptive_median_baseline_detector_unit_macros.svh
// Assertion macros for the adaptive median baseline detector.
`ifndef ADAPTIVE_MEDIAN_BASELINE_DETECTOR_UNIT_MACROS_SVH
`define ADAPTIVE_MEDIAN_BASELINE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define AMBD_IMPLY(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define AMBD_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) else $error(msg);

`endif

>>> hw/rtl/ambd_pkg.sv
// Package: shared constants of the median baseline detector.
`timescale 1ns / 1ps
`default_nettype none
package ambd_pkg;
    localparam int WINDOW_DEF      = 100;
    localparam int CHANNELS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CH_W            = 4;
    localparam int GAIN_W          = 9;
    localparam int GAIN_FRAC       = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd269;
endpackage
`default_nettype wire

>>> hw/rtl/ambd_if.sv
// Interfaces: sample request, result request and gain write channels.
`timescale 1ns / 1ps
`default_nettype none
interface ambd_in_if import ambd_pkg::*; #(parameter int SB = SAMPLE_BITS_DEF);
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic [SB-1:0]   sample;
    modport source (output valid, channel, sample, input ready);
    modport sink   (input valid, channel, sample, output ready);
endinterface

interface ambd_out_if #(parameter int SB = ambd_pkg::SAMPLE_BITS_DEF);
    logic          valid;
    logic          ready;
    logic          detected;
    logic          accepted;
    logic          filled;
    logic [SB:0]   median_x2;
    modport source (output valid, detected, accepted, filled, median_x2, input ready);
    modport sink   (input valid, detected, accepted, filled, median_x2, output ready);
endinterface

interface ambd_cfg_if import ambd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/adaptive_median_baseline_detector_unit.sv
// Top level: per-channel windowed median baseline with threshold detection.
// Steps: a channel still filling or out of range goes from idle to the done state; a full
// window first runs one radix select pass over the window memory per sample bit, one
// read a cycle, then the multiply and compare states, before the result is registered.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: synchronous active low; loads the default gain, clears pointers and fill counts.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_median_baseline_detector_unit import ambd_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ambd_in_if.sink    i_in,
    ambd_out_if.source o_out,
    ambd_cfg_if.sink   i_cfg
);
    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = $clog2(WINDOW + 1);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(SB);
    localparam int PRW   = SB + 1 + GAIN_W;
    localparam logic [PW-1:0] W_LAST = PW'(WINDOW - 1);
    localparam logic [PW-1:0] W_FULL = PW'(WINDOW);
    localparam logic [PW-1:0] KA0    = PW'((WINDOW - 1) / 2);
    localparam logic [PW-1:0] KB0    = PW'(WINDOW / 2);
    localparam logic [SB-1:0] ONES   = '1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_CMP, S_DONE} t_state;

    t_state            r_state;
    logic [GAIN_W-1:0] r_gain;
    logic [PW-1:0]     r_wp   [CHANNELS];
    logic [PW-1:0]     r_fill [CHANNELS];
    logic [SB-1:0]     r_mem  [DEPTH];
    logic [SB-1:0]     r_rd;
    logic [CH_W-1:0]   r_ch;
    logic [SB-1:0]     r_smp;
    logic [AW-1:0]     r_base;
    logic [PW-1:0]     r_j;
    logic              r_rv, r_rlast;
    logic [BW-1:0]     r_bit;
    logic [SB-1:0]     r_pa, r_pb;
    logic [PW-1:0]     r_ka, r_kb, r_ca, r_cb;
    logic [PRW-1:0]    r_prod;
    logic              r_det, r_acc, r_full;
    logic [SB:0]       r_mx2;
    logic              r_ov, r_odet, r_oacc, r_ofull;
    logic [SB:0]       r_omx2;

    logic              in_go, in_rng;
    logic [CW-1:0]     in_idx, ch_idx;
    logic              we;
    logic [AW-1:0]     wa, ra, in_base;
    logic [SB-1:0]     wd;
    logic [SB-1:0]     mask;
    logic              hit_a, hit_b;
    logic [PW-1:0]     n_ca, n_cb;
    logic [SB:0]       mx2;
    logic [PRW-1:0]    lhs;
    logic              cmp_acc, cmp_det;
    logic              out_free;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_go   = i_in.valid & i_in.ready;
    assign in_idx  = CW'(i_in.channel);
    assign ch_idx  = CW'(r_ch);
    assign in_rng  = (32'(i_in.channel) < CHANNELS);
    assign in_base = AW'(32'(in_idx) * WINDOW);

    assign mask  = (ONES << r_bit) << 1;
    assign hit_a = ((r_rd & mask) == r_pa) && !r_rd[r_bit];
    assign hit_b = ((r_rd & mask) == r_pb) && !r_rd[r_bit];
    assign n_ca  = r_ca + PW'(hit_a);
    assign n_cb  = r_cb + PW'(hit_b);
    assign mx2   = {1'b0, r_pa} + {1'b0, r_pb};
    assign lhs   = PRW'({r_smp, {(GAIN_FRAC + 1){1'b0}}});
    assign cmp_acc = lhs < r_prod;
    assign cmp_det = lhs > r_prod;
    assign ra    = r_base + AW'(r_j);
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        we = 1'b0;
        wa = r_base + AW'(r_wp[ch_idx]);
        wd = r_smp;
        if (in_go && in_rng && (r_fill[in_idx] < W_FULL)) begin
            we = 1'b1;
            wa = in_base + AW'(r_wp[in_idx]);
            wd = i_in.sample;
        end else if (r_state == S_CMP && cmp_acc) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain  <= GAIN_RESET;
            r_ov    <= 1'b0;
            r_rv    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c]   <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_gain <= i_cfg.data;
            end
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            r_rv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_go) begin
                        r_ch   <= i_in.channel;
                        r_smp  <= i_in.sample;
                        r_base <= in_base;
                        r_det  <= 1'b0;
                        r_full <= 1'b0;
                        r_mx2  <= '0;
                        r_acc  <= 1'b0;
                        r_state <= S_DONE;
                        if (in_rng) begin
                            if (r_fill[in_idx] < W_FULL) begin
                                r_acc <= 1'b1;
                                r_fill[in_idx] <= r_fill[in_idx] + 1'b1;
                                r_wp[in_idx] <= (r_wp[in_idx] == W_LAST) ? '0
                                                : r_wp[in_idx] + 1'b1;
                            end else begin
                                r_full  <= 1'b1;
                                r_j     <= '0;
                                r_bit   <= BW'(SB - 1);
                                r_pa    <= '0;
                                r_pb    <= '0;
                                r_ka    <= KA0;
                                r_kb    <= KB0;
                                r_ca    <= '0;
                                r_cb    <= '0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_j < W_FULL) begin
                        r_j    <= r_j + 1'b1;
                        r_rv   <= 1'b1;
                        r_rlast <= (r_j == W_LAST);
                    end
                    if (r_rv) begin
                        r_ca <= n_ca;
                        r_cb <= n_cb;
                        if (r_rlast) begin
                            r_ca <= '0;
                            r_cb <= '0;
                            r_j  <= '0;
                            if (r_ka >= n_ca) begin
                                r_pa <= r_pa | (SB'(1) << r_bit);
                                r_ka <= r_ka - n_ca;
                            end
                            if (r_kb >= n_cb) begin
                                r_pb <= r_pb | (SB'(1) << r_bit);
                                r_kb <= r_kb - n_cb;
                            end
                            if (r_bit == '0) begin
                                r_state <= S_MUL;
                            end else begin
                                r_bit <= r_bit - 1'b1;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_mx2   <= mx2;
                    r_prod  <= PRW'(mx2) * PRW'(r_gain);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_acc <= cmp_acc;
                    r_det <= cmp_det;
                    if (cmp_acc) begin
                        r_wp[ch_idx] <= (r_wp[ch_idx] == W_LAST) ? '0
                                        : r_wp[ch_idx] + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_odet  <= r_det;
                        r_oacc  <= r_acc;
                        r_ofull <= r_full;
                        r_omx2  <= r_mx2;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.detected  = r_odet;
    assign o_out.accepted  = r_oacc;
    assign o_out.filled    = r_ofull;
    assign o_out.median_x2 = r_omx2;
endmodule
`default_nettype wire

>>> hw/rtl/ambd_check.sv
// Checker: port-level properties of the detector results, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_median_baseline_detector_unit_macros.svh"
module ambd_check #(
    parameter int SB = ambd_pkg::SAMPLE_BITS_DEF
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire        i_detected,
    input wire        i_accepted,
    input wire        i_filled,
    input wire [SB:0] i_median_x2
);
    `AMBD_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid, "result dropped")
    `AMBD_IMPLY(a_det_full, i_clk, i_rst_n, i_valid && i_detected, i_filled, "detect unfilled")
    `AMBD_IMPLY(a_det_acc, i_clk, i_rst_n, i_valid && i_detected, !i_accepted, "detect and add")
    `AMBD_IMPLY(a_med_zero, i_clk, i_rst_n, i_valid && !i_filled, i_median_x2 == '0,
                "median while filling")
endmodule

bind adaptive_median_baseline_detector_unit ambd_check #(.SB(SAMPLE_BITS)) u_ambd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_detected  (o_out.detected),
    .i_accepted  (o_out.accepted),
    .i_filled    (o_out.filled),
    .i_median_x2 (o_out.median_x2)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench: per-channel median baseline detector checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import ambd_pkg::*;

    localparam int NWIN = WINDOW_DEF;
    localparam int NCH = CHANNELS_DEF;
    localparam int SB = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SQUEEZE_CYCLES = 3000;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [SB-1:0] sample;
    } sample_req_t;

    typedef struct packed {
        logic detected;
        logic accepted;
        logic filled;
        logic [SB:0] median_x2;
    } verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ambd_in_if #(.SB(SB)) smp_ch();
    ambd_out_if #(.SB(SB)) res_ch();
    ambd_cfg_if cfg_ch();

    adaptive_median_baseline_detector_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(smp_ch),
        .o_out(res_ch),
        .i_cfg(cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sample_req_t pending_q[$];
    verdict_t verdict_q[$];
    logic [SB-1:0] win_mem[NCH][NWIN];
    int wr_ptr[NCH];
    int fill_cnt[NCH];
    logic [GAIN_W-1:0] gain_now;
    int mismatches = 0;
    int cycles = 0;
    int send_gap = 0;
    int rcv_stall = 0;
    bit steady = 0;
    bit squeeze = 0;
    int squeeze_cnt = 0;

    function automatic logic [SB:0] window_median_x2(input int ch);
        logic [SB-1:0] s[NWIN];
        logic [SB-1:0] v;
        int j;
        for (int i = 0; i < NWIN; i++) s[i] = win_mem[ch][i];
        for (int i = 1; i < NWIN; i++) begin
            v = s[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
        end
        if (NWIN % 2 == 1) return {s[NWIN/2], 1'b0};
        return {1'b0, s[NWIN/2-1]} + {1'b0, s[NWIN/2]};
    endfunction

    function automatic verdict_t detect_sample(input sample_req_t r);
        verdict_t v;
        longint lhs, rhs;
        int ch;
        v = '0;
        ch = int'(r.channel);
        if (ch >= NCH) return v;
        if (fill_cnt[ch] >= NWIN) begin
            v.filled = 1'b1;
            v.median_x2 = window_median_x2(ch);
            lhs = longint'(r.sample) * 512;
            rhs = longint'(v.median_x2) * longint'(gain_now);
            v.accepted = lhs < rhs;
            v.detected = lhs > rhs;
        end else begin
            v.accepted = 1'b1;
        end
        if (v.accepted) begin
            win_mem[ch][wr_ptr[ch]] = r.sample;
            wr_ptr[ch] = (wr_ptr[ch] + 1) % NWIN;
            if (fill_cnt[ch] < NWIN) fill_cnt[ch]++;
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_ch.valid <= 1'b0;
            smp_ch.channel <= '0;
            smp_ch.sample <= '0;
        end else begin
            if (smp_ch.valid && smp_ch.ready)
                verdict_q.push_back(detect_sample({smp_ch.channel, smp_ch.sample}));
            if (!smp_ch.valid || smp_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    smp_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    sample_req_t r;
                    r = pending_q.pop_front();
                    smp_ch.valid <= 1'b1;
                    smp_ch.channel <= r.channel;
                    smp_ch.sample <= r.sample;
                    send_gap = pick_gap();
                end else begin
                    smp_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off
    always @(posedge i_clk) begin
        if (squeeze && squeeze_cnt < SQUEEZE_CYCLES) squeeze_cnt <= squeeze_cnt + 1;
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                verdict_t got, want;
                got = {res_ch.detected, res_ch.accepted, res_ch.filled, res_ch.median_x2};
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: det=%0d acc=%0d fil=%0d mx2=%0d",
                                 got.detected, got.accepted, got.filled, got.median_x2);
                end else begin
                    want = verdict_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp det=%0d acc=%0d fil=%0d mx2=%0d, ",
                                      "got %0d %0d %0d %0d"},
                                     want.detected, want.accepted, want.filled,
                                     want.median_x2, got.detected,
                                     got.accepted, got.filled, got.median_x2);
                    end
                end
            end
            if (squeeze && squeeze_cnt < SQUEEZE_CYCLES) begin
                res_ch.ready <= 1'b0;
            end else if (rcv_stall > 0) begin
                rcv_stall--;
                res_ch.ready <= 1'b0;
            end else if (steady) begin
                res_ch.ready <= 1'b1;
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 3) rcv_stall = $urandom_range(10, 60);
                res_ch.ready <= (r >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("adaptive_median_baseline_detector_unit regression: fail");
            $finish;
        end
    end

    task automatic wait_idle();
        forever begin
            @(posedge i_clk);
            if (pending_q.size() == 0 && verdict_q.size() == 0 && !smp_ch.valid
                && send_gap == 0) break;
        end
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= g;
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        gain_now = g;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_req(input int ch, input int s);
        sample_req_t r;
        r.channel = ch[CH_W-1:0];
        r.sample = s[SB-1:0];
        pending_q.push_back(r);
    endtask

    task automatic fill_channel(input int ch, input int lo, input int hi);
        for (int i = 0; i < NWIN; i++) push_req(ch, $urandom_range(lo, hi));
    endtask

    task automatic random_burst(input int n);
        int full_chs[4] = '{0, 15, 3, 9};
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                if (r < 40) push_req(full_chs[$urandom_range(0, 3)], $urandom_range(0, 1023));
                else push_req(full_chs[$urandom_range(0, 3)], $urandom_range(350, 700));
            end else begin
                push_req($urandom_range(0, NCH - 1), $urandom_range(0, 1023));
            end
        end
    endtask

    initial begin
        smp_ch.valid = 1'b0;
        smp_ch.channel = '0;
        smp_ch.sample = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        gain_now = GAIN_RESET;
        for (int c = 0; c < NCH; c++) begin
            wr_ptr[c] = 0;
            fill_cnt[c] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flat window: at gain 1.0 a sample equal to the median ties the threshold
        write_gain(9'd256);
        steady = 1;
        for (int i = 0; i < NWIN; i++) push_req(0, 500);
        fill_channel(15, 0, 1023);
        push_req(7, 0);
        push_req(7, 1023);
        push_req(0, 500);
        push_req(0, 499);
        push_req(0, 501);
        push_req(0, 0);
        push_req(0, 1023);
        push_req(15, 0);
        push_req(15, 1023);
        push_req(15, 500);
        wait_idle();
        steady = 0;

        write_gain(9'd511);
        squeeze = 1;
        fill_channel(3, 100, 500);
        fill_channel(9, 0, 1023);
        push_req(0, 500);
        push_req(0, 1023);
        push_req(3, 1023);
        random_burst(200);

        write_gain(GAIN_RESET);
        random_burst(200);

        write_gain(9'd256);
        steady = 1;
        random_burst(60);
        wait_idle();
        steady = 0;
        random_burst(120);

        write_gain(GAIN_W'($urandom_range(256, 511)));
        random_burst(200);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("adaptive_median_baseline_detector_unit regression: pass");
        else
            $display("adaptive_median_baseline_detector_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

>>> adaptive_median_baseline_detector_unit.f
+incdir+hw/rtl
hw/rtl/ambd_pkg.sv
hw/rtl/ambd_if.sv
hw/rtl/adaptive_median_baseline_detector_unit.sv
hw/rtl/ambd_check.sv
tb/sv/tb_top.sv
